// File: sv/act_pkg.sv
// Package for the box contact tracker: event codes, sizes, state enum.
// No dependencies.
package act_pkg;

    localparam int TableDepthDef = 64;
    localparam int CoordBitsDef  = 16;
    localparam int IdBits        = 32;
    localparam int QueueDepth    = 2;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_BEGIN = 2'd1,
        EV_STAY  = 2'd2,
        EV_END   = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } t_state;

    // Classified beat passed from the front to the back
    typedef struct packed {
        logic [IdBits-1:0] left_id;
        logic [IdBits-1:0] partner_id;
        logic              overlap;
        logic              dead;
        logic              stateless;
    } t_job;

endpackage

// File: sv/act_if.sv
// Valid/ready channel interface with a generic payload type.
// Depends on nothing; payload type given by the user.
interface act_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/act_front.sv
// Front: overlap test on both axes, classification into a job beat.
// Depends on act_pkg.
module act_front import act_pkg::*; #(
    parameter int COORD_BITS = CoordBitsDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IdBits-1:0]     i_left_id,
    input  logic [IdBits-1:0]     i_right_id,
    input  logic signed [COORD_BITS-1:0] i_left_x,
    input  logic signed [COORD_BITS-1:0] i_left_y,
    input  logic [COORD_BITS-1:0] i_left_w,
    input  logic [COORD_BITS-1:0] i_left_h,
    input  logic signed [COORD_BITS-1:0] i_right_x,
    input  logic signed [COORD_BITS-1:0] i_right_y,
    input  logic [COORD_BITS-1:0] i_right_w,
    input  logic [COORD_BITS-1:0] i_right_h,
    input  logic                  i_either_dead,
    input  logic                  i_stateless_check,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_job                  o_job
);
    localparam int DW = COORD_BITS + 1;
    localparam int SW = COORD_BITS + 2;

    logic signed [DW-1:0] dx, dy;
    logic [DW-1:0] ax, ay;
    logic [SW-1:0] sx, sy;
    logic ov;
    t_job r_job;
    logic r_valid;

    // Strict test: 2*|d| < wl + wr on each axis
    always_comb begin
        dx = DW'(i_left_x) - DW'(i_right_x);
        dy = DW'(i_left_y) - DW'(i_right_y);
        ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
        sx = SW'(i_left_w) + SW'(i_right_w);
        sy = SW'(i_left_h) + SW'(i_right_h);
        ov = ({ax, 1'b0} < sx) && ({ay, 1'b0} < sy);
    end

    assign o_ready = !r_valid || i_ready;

    // Hold one classified beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_job <= '{left_id: i_left_id, partner_id: i_right_id, overlap: ov,
                       dead: i_either_dead, stateless: i_stateless_check};
        end
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;
endmodule

// File: sv/act_queue.sv
// Short FIFO of job beats between front and back.
// Depends on act_pkg.
module act_queue import act_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);
    localparam int AW = $clog2(QueueDepth);

    t_job r_mem [QueueDepth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != (AW+1)'(QueueDepth);
    assign o_valid = r_cnt != '0;
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;
    assign o_job = r_mem[r_rp];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
        if (push) r_mem[r_wp] <= i_job;
    end
endmodule

// File: sv/act_back.sv
// Back: walks the pair-key memory, inserts, updates touching, emits result.
// Depends on act_pkg.
module act_back import act_pkg::*; #(
    parameter int TABLE_DEPTH = TableDepthDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_job       i_job,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_contact_event,
    output logic       o_overlapping,
    output logic       o_table_full
);
    localparam int AW = $clog2(TABLE_DEPTH);

    logic [2*IdBits-1:0] r_key_mem [TABLE_DEPTH];
    logic r_touch_mem [TABLE_DEPTH];
    logic [AW:0] r_fill, r_idx, n_idx;
    logic [2*IdBits-1:0] r_rd;
    logic r_rd_touch;
    logic r_rd_ok;
    t_state r_state, n_state;
    t_job r_job;
    logic [2*IdBits-1:0] key;
    logic hit, at_end, take;
    logic [AW-1:0] slot;
    logic was, new_touch, write_touch, insert;
    t_event ev;
    logic full;
    logic r_ovalid;
    logic [1:0] r_ev, r_p_ev;
    logic r_ov, r_full, r_p_ov, r_p_full;

    assign key    = {r_job.partner_id, r_job.left_id};
    assign hit    = r_rd_ok && (r_rd == key);
    assign at_end = (r_idx == r_fill);
    assign o_ready = (r_state == ST_IDLE);
    assign take   = i_valid && o_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_valid) n_state = i_job.stateless ? ST_DONE : ST_SEARCH;
            ST_SEARCH: if (hit || (at_end && !r_rd_ok)) n_state = ST_DONE;
            ST_DONE:   if (!r_ovalid || i_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Decide event from old touching bit, overlap and dead flag
    always_comb begin
        slot = hit ? r_idx[AW-1:0] - 1'b1 : r_fill[AW-1:0];
        full = !hit && (r_fill == (AW+1)'(TABLE_DEPTH));
        insert = !hit && !full;
        was = hit ? r_rd_touch : 1'b0;
        ev = EV_NONE;
        new_touch = was;
        if (r_job.overlap) begin
            if (!was) begin
                if (!r_job.dead) begin
                    ev = EV_BEGIN;
                    new_touch = 1'b1;
                end
            end else if (r_job.dead) begin
                ev = EV_END;
                new_touch = 1'b0;
            end else begin
                ev = EV_STAY;
            end
        end else if (was) begin
            ev = EV_END;
            new_touch = 1'b0;
        end
        if (full) ev = EV_NONE;
        write_touch = (r_state == ST_SEARCH) && (n_state == ST_DONE) && !full;
        n_idx = r_idx + 1'b1;
    end

    // Sequencer, memory walk and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
            r_rd_ok  <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_idx   <= '0;
                    r_rd_ok <= 1'b0;
                    if (take) r_job <= i_job;
                    if (take && i_job.stateless) begin
                        r_p_ev   <= i_job.overlap ? EV_BEGIN : EV_NONE;
                        r_p_ov   <= i_job.overlap;
                        r_p_full <= 1'b0;
                    end
                end
                ST_SEARCH: begin
                    r_rd_ok <= !at_end && !hit;
                    if (!at_end) r_idx <= n_idx;
                    if (write_touch && insert) r_fill <= r_fill + 1'b1;
                    if (n_state == ST_DONE) begin
                        r_p_ev   <= ev;
                        r_p_ov   <= r_job.overlap;
                        r_p_full <= full;
                    end
                end
                ST_DONE: begin
                    // Load the output only once the previous beat has left
                    if (!r_ovalid || i_ready) begin
                        r_ev   <= r_p_ev;
                        r_ov   <= r_p_ov;
                        r_full <= r_p_full;
                    end
                end
                default: ;
            endcase
        end
        if (r_state == ST_SEARCH && !at_end) begin
            r_rd       <= r_key_mem[r_idx[AW-1:0]];
            r_rd_touch <= r_touch_mem[r_idx[AW-1:0]];
        end
        if (write_touch) r_touch_mem[slot] <= new_touch;
        if (write_touch && insert) r_key_mem[slot] <= key;
    end

    assign o_valid         = r_ovalid;
    assign o_contact_event = r_ev;
    assign o_overlapping   = r_ov;
    assign o_table_full    = r_full;
endmodule

// File: sv/aabb_contact_tracker.sv
// channel | dir | payload
// s_in    | in  | ids, boxes, either_dead, stateless_check
// m_out   | out | contact_event, overlapping, table_full
//
// A beat passes the front register and the queue, then the back walks the
// pair-key memory one entry a cycle through its single read port and
// registers the result. The back takes no new beat until it has loaded the
// last one into its output register. Stateless beats skip the walk.
// Synchronous active-low reset empties the table at once via the fill count.
// Either side may stall; a two-beat queue parts front/back.
// Depends on act_pkg, act_if, act_front, act_queue, act_back.
module aabb_contact_tracker import act_pkg::*; #(
    parameter int TABLE_DEPTH = TableDepthDef,
    parameter int COORD_BITS  = CoordBitsDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IdBits-1:0]     i_left_id,
    input  logic [IdBits-1:0]     i_right_id,
    input  logic signed [COORD_BITS-1:0] i_left_x,
    input  logic signed [COORD_BITS-1:0] i_left_y,
    input  logic [COORD_BITS-1:0] i_left_w,
    input  logic [COORD_BITS-1:0] i_left_h,
    input  logic signed [COORD_BITS-1:0] i_right_x,
    input  logic signed [COORD_BITS-1:0] i_right_y,
    input  logic [COORD_BITS-1:0] i_right_w,
    input  logic [COORD_BITS-1:0] i_right_h,
    input  logic                  i_either_dead,
    input  logic                  i_stateless_check,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_contact_event,
    output logic                  o_overlapping,
    output logic                  o_table_full
);
    act_if #(.T(t_job)) front_q ();
    act_if #(.T(t_job)) q_back ();

    act_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_left_id, .i_right_id, .i_left_x, .i_left_y, .i_left_w, .i_left_h,
        .i_right_x, .i_right_y, .i_right_w, .i_right_h,
        .i_either_dead, .i_stateless_check,
        .o_valid(front_q.valid), .i_ready(front_q.ready), .o_job(front_q.data)
    );

    act_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(front_q.valid), .o_ready(front_q.ready), .i_job(front_q.data),
        .o_valid(q_back.valid), .i_ready(q_back.ready), .o_job(q_back.data)
    );

    act_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_back.valid), .o_ready(q_back.ready), .i_job(q_back.data),
        .o_valid, .i_ready, .o_contact_event, .o_overlapping, .o_table_full
    );
endmodule

// File: sv/act_checker.sv
// Port-level checks on the tracker, bound to the top level.
// Depends on act_pkg.
module act_checker import act_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_contact_event,
    input logic       o_overlapping,
    input logic       o_table_full
);
    // Stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_contact_event))
        else $error("result changed under stall");
    // Full table emits nothing
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_table_full |-> o_contact_event == EV_NONE)
        else $error("event on full table");
    // Begin and stay need overlap
    a_ov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_contact_event == EV_BEGIN || o_contact_event == EV_STAY)
        |-> o_overlapping)
        else $error("begin or stay without overlap");
    // Reset clears valid
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind aabb_contact_tracker act_checker u_checker (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_contact_event,
    .o_overlapping, .o_table_full
);
